FILE: design/vpf_pkg.sv
// ----------------------------------------------------------------------------
// vpf_pkg
// Shared types and constants for the valve PID controller with feedforward.
// ----------------------------------------------------------------------------
package vpf_pkg;

    // width of the shared serial arithmetic datapath
    localparam int OP_W     = 64;
    localparam int MUL_BW   = 32;
    localparam int DIV_DW   = 20;
    localparam int STEP_W   = 6;

    // fixed constants of the control law
    localparam int POS_SCALE    = 5000;
    localparam int PID_SPAN     = 130000;
    localparam int INTEG_LIMIT  = 20480000;
    localparam int ERR_DEADBAND = 50;
    localparam int ANGLE_STEP   = 50;
    localparam int DT_MAX       = 15;
    localparam int DT_DEFAULT   = 10;
    localparam int DUTY_SPAN    = 510;
    localparam int DUTY_MAX     = 255;

    // digit counts of each serial operation (bits of multiplier or quotient)
    localparam int FF_MUL_N  = 8;
    localparam int FF_DIV_N  = 24;
    localparam int POS_MUL_N = 13;
    localparam int POS_DIV_N = 28;
    localparam int GAIN_N    = 24;
    localparam int DT_N      = 4;
    localparam int D_DIV_N   = 48;
    localparam int M_MUL_N   = 9;
    localparam int M_DIV_N   = 52;

    typedef enum logic [2:0] {
        REG_SENSOR_CLOSED = 3'd0,
        REG_SENSOR_OPEN   = 3'd1,
        REG_PWM_OPEN      = 3'd2,
        REG_PWM_CLOSED    = 3'd3,
        REG_GAIN_PROP     = 3'd4,
        REG_GAIN_DERIV    = 3'd5,
        REG_GAIN_INTEG    = 3'd6
    } vpf_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FF_MUL,
        ST_FF_DIV,
        ST_POS_MUL,
        ST_POS_DIV,
        ST_ERR,
        ST_P_MUL,
        ST_I_MUL,
        ST_I_DT,
        ST_D_MUL,
        ST_D_DIV,
        ST_PID,
        ST_M_MUL,
        ST_M_DIV,
        ST_DONE
    } vpf_state_t;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } vpf_cmd_t;

endpackage

FILE: design/vpf_mul.sv
// ----------------------------------------------------------------------------
// vpf_mul
// Signed shift-and-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module vpf_mul
    import vpf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  vpf_cmd_t                 cmd,
    input  logic signed [OP_W-1:0]   a,
    input  logic signed [MUL_BW-1:0] b,
    output logic                     done,
    output logic signed [OP_W-1:0]   prod
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [OP_W-1:0]   a_reg;
    logic [MUL_BW-1:0] b_reg;
    logic [OP_W-1:0]   acc_reg;
    logic              neg_reg;
    logic [OP_W-1:0]   a_mag;
    logic [MUL_BW-1:0] b_mag;

    assign a_mag = a[OP_W-1] ? OP_W'(-a) : OP_W'(a);
    assign b_mag = b[MUL_BW-1] ? MUL_BW'(-b) : MUL_BW'(b);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cmd.steps;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // shift multiplicand left, multiplier right, add one partial product
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            a_reg   <= a_mag;
            b_reg   <= b_mag;
            acc_reg <= '0;
            neg_reg <= a[OP_W-1] ^ b[MUL_BW-1];
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_reg <= acc_reg + a_reg;
            end
            a_reg <= {a_reg[OP_W-2:0], 1'b0};
            b_reg <= {1'b0, b_reg[MUL_BW-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = neg_reg ? -$signed(acc_reg) : $signed(acc_reg);

endmodule

FILE: design/vpf_div.sv
// ----------------------------------------------------------------------------
// vpf_div
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module vpf_div
    import vpf_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  vpf_cmd_t                 cmd,
    input  logic signed [OP_W-1:0]   dvd,
    input  logic signed [DIV_DW-1:0] dsr,
    output logic                     done,
    output logic signed [OP_W-1:0]   quo
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [OP_W-1:0]   q_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dsr_reg;
    logic              neg_reg;
    logic [OP_W-1:0]   dvd_mag;
    logic [DIV_DW-1:0] dsr_mag;
    logic [DIV_DW-1:0] shifted;
    logic              fits;

    assign dvd_mag = dvd[OP_W-1] ? OP_W'(-dvd) : OP_W'(dvd);
    assign dsr_mag = dsr[DIV_DW-1] ? DIV_DW'(-dsr) : DIV_DW'(dsr);
    assign shifted = {rem_reg[DIV_DW-2:0], q_reg[OP_W-1]};
    assign fits    = (shifted >= dsr_reg);

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = cmd.steps;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // align the dividend so its top digit leaves first
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            q_reg   <= dvd_mag << (7'(OP_W) - {1'b0, cmd.steps});
            rem_reg <= '0;
            dsr_reg <= dsr_mag;
            neg_reg <= dvd[OP_W-1] ^ dsr[DIV_DW-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? (shifted - dsr_reg) : shifted;
            q_reg   <= {q_reg[OP_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

FILE: design/valve_pid_with_feedforward_core.sv
// ----------------------------------------------------------------------------
// valve_pid_with_feedforward_core
// Valve position PID controller with a feedforward term, digit-serial datapath.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    samples a..d, close_angle, elapsed_ms
//  m_*       out  m_tvalid/m_tready    duty, sensor_value
//  cfg_*     in   cfg_we               cfg_index, cfg_data (no read-back)
//
//  Each word runs its steps back to back through a shared shift-and-add
//  multiplier and a shared restoring divider, one bit per cycle; a zero
//  sensor span skips both maps and an error inside the dead band skips the
//  integral steps. Reset (rst_n low, asynchronous) restores register
//  defaults and clears the stored position and integral. The result waits
//  in an output register; the next word is taken the cycle after it loads,
//  and the last step holds only while the earlier result is unread.
// ----------------------------------------------------------------------------
module valve_pid_with_feedforward_core
    import vpf_pkg::*;
#(
    parameter int SAMPLE_BITS = 12
)
(
    input  logic clk,
    input  logic rst_n,
    // sample_a, sample_b, sample_c, sample_d, close_angle[6:0], elapsed_ms[15:0]
    input  logic [((4*SAMPLE_BITS+23+7)/8)*8-1:0] s_tdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // duty[7:0], sensor_value[10:0], zero fill
    output logic [23:0] m_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int SUM_W = SAMPLE_BITS + 2;
    localparam int S_W   = SAMPLE_BITS - 1;

    // configuration registers
    logic [12:0] closed_reg, open_reg;
    logic [7:0]  pwm_open_reg, pwm_closed_reg;
    logic [23:0] kp_reg, kd_reg, ki_reg;

    // per-word state
    vpf_state_t         state_reg, state_next;
    logic               launch_reg;
    logic [S_W-1:0]     s_reg;
    logic [6:0]         angle_reg;
    logic [3:0]         dt_reg;
    logic signed [25:0] ff_reg;
    logic signed [23:0] pos_reg;
    logic signed [23:0] last_reg;
    logic signed [25:0] err_reg;
    logic signed [25:0] dp_reg;
    logic signed [49:0] p_reg;
    logic signed [49:0] d_reg;
    logic signed [27:0] integ_reg;
    logic signed [43:0] pid_reg;
    logic [7:0]         duty_reg;
    logic [7:0]         m_duty_reg;
    logic [10:0]        m_sensor_reg;
    logic               m_valid_reg;

    // input unpack
    logic [SAMPLE_BITS-1:0] smp_a, smp_b, smp_c, smp_d;
    logic [6:0]             in_angle;
    logic [15:0]            in_el;
    logic [SUM_W-1:0]       smp_sum;
    logic [3:0]             in_dt;
    logic                   span_zero;
    logic                   take_in;

    assign smp_a    = s_tdata[0*SAMPLE_BITS +: SAMPLE_BITS];
    assign smp_b    = s_tdata[1*SAMPLE_BITS +: SAMPLE_BITS];
    assign smp_c    = s_tdata[2*SAMPLE_BITS +: SAMPLE_BITS];
    assign smp_d    = s_tdata[3*SAMPLE_BITS +: SAMPLE_BITS];
    assign in_angle = s_tdata[4*SAMPLE_BITS +: 7];
    assign in_el    = s_tdata[4*SAMPLE_BITS+7 +: 16];
    assign smp_sum  = SUM_W'(smp_a) + SUM_W'(smp_b) + SUM_W'(smp_c) + SUM_W'(smp_d);
    // elapsed time outside 1..15 falls back to the default tick
    assign in_dt    = (in_el == 16'd0 || in_el > 16'(DT_MAX)) ? 4'(DT_DEFAULT)
                                                               : in_el[3:0];
    assign span_zero = (closed_reg == open_reg);
    assign take_in   = s_tvalid && s_tready;

    // shared serial units
    vpf_cmd_t                  mul_cmd, div_cmd;
    logic signed [OP_W-1:0]    mul_a, mul_prod;
    logic signed [MUL_BW-1:0]  mul_b;
    logic signed [OP_W-1:0]    div_dvd, div_quo;
    logic signed [DIV_DW-1:0]  div_dsr;
    logic                      mul_done, div_done;

    vpf_mul u_mul
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_cmd),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    vpf_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .dvd   (div_dvd),
        .dsr   (div_dsr),
        .done  (div_done),
        .quo   (div_quo)
    );

    // operand views
    logic signed [OP_W-1:0]    s_wide, closed_wide, open_wide;
    logic signed [MUL_BW-1:0]  pwm_diff;
    logic signed [DIV_DW-1:0]  span_oc, span_co;
    logic signed [OP_W-1:0]    err_wide, dp_wide, pid_off;

    assign s_wide      = {{(OP_W-S_W){1'b0}}, s_reg};
    assign closed_wide = {{(OP_W-13){1'b0}}, closed_reg};
    assign open_wide   = {{(OP_W-13){1'b0}}, open_reg};
    assign pwm_diff    = {{(MUL_BW-8){1'b0}}, pwm_open_reg}
                       - {{(MUL_BW-8){1'b0}}, pwm_closed_reg};
    assign span_oc     = {{(DIV_DW-13){1'b0}}, open_reg} - {{(DIV_DW-13){1'b0}}, closed_reg};
    assign span_co     = {{(DIV_DW-13){1'b0}}, closed_reg} - {{(DIV_DW-13){1'b0}}, open_reg};
    assign err_wide    = {{(OP_W-26){err_reg[25]}}, err_reg};
    assign dp_wide     = {{(OP_W-26){dp_reg[25]}}, dp_reg};
    assign pid_off     = {{(OP_W-44){pid_reg[43]}}, pid_reg} + OP_W'(PID_SPAN);

    // derived values taken at the end of steps
    logic signed [25:0] ff_val;
    logic signed [23:0] pos_val;
    logic [12:0]        setpoint;
    logic signed [25:0] err_val, dp_val;
    logic               outside_band;
    logic signed [55:0] isum;
    logic signed [27:0] integ_val;
    logic signed [51:0] pid_sum, pid_rnd;
    logic signed [39:0] duty_tot;
    logic [7:0]         duty_val;

    assign ff_val = div_quo[25:0] + {18'b0, pwm_closed_reg};

    // saturate position to the signed 24-bit range
    always_comb
    begin
        if (div_quo > 64'sd8388607)
        begin
            pos_val = 24'sh7FFFFF;
        end
        else if (div_quo < -64'sd8388608)
        begin
            pos_val = -24'sd8388608;
        end
        else
        begin
            pos_val = div_quo[23:0];
        end
    end

    assign setpoint     = 13'(angle_reg) * 13'(ANGLE_STEP);
    assign err_val      = {13'b0, setpoint} - {{2{pos_reg[23]}}, pos_reg};
    assign dp_val       = {{2{pos_reg[23]}}, pos_reg} - {{2{last_reg[23]}}, last_reg};
    assign outside_band = (err_reg > 26'sd50) || (err_reg < -26'sd50);

    // integral update, clamped to the limit in Q8
    assign isum = {{28{integ_reg[27]}}, integ_reg} + mul_prod[55:0];
    always_comb
    begin
        if (isum > 56'sd20480000)
        begin
            integ_val = 28'sd20480000;
        end
        else if (isum < -56'sd20480000)
        begin
            integ_val = -28'sd20480000;
        end
        else
        begin
            integ_val = isum[27:0];
        end
    end

    // drop the Q8 fraction, rounding toward zero
    assign pid_sum = {{2{p_reg[49]}}, p_reg} - {{2{d_reg[49]}}, d_reg}
                   + {{24{integ_reg[27]}}, integ_reg};
    assign pid_rnd = pid_sum[51] ? (pid_sum + 52'sd255) : pid_sum;

    assign duty_tot = div_quo[39:0] - 40'(DUTY_MAX) + {{14{ff_reg[25]}}, ff_reg};
    always_comb
    begin
        if (duty_tot[39])
        begin
            duty_val = 8'd0;
        end
        else if (duty_tot > 40'sd255)
        begin
            duty_val = 8'(DUTY_MAX);
        end
        else
        begin
            duty_val = duty_tot[7:0];
        end
    end

    logic op_done;
    assign op_done = mul_done || div_done;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (take_in)
                begin
                    state_next = span_zero ? ST_ERR : ST_FF_MUL;
                end
            end
            ST_FF_MUL:  if (mul_done) state_next = ST_FF_DIV;
            ST_FF_DIV:  if (div_done) state_next = ST_POS_MUL;
            ST_POS_MUL: if (mul_done) state_next = ST_POS_DIV;
            ST_POS_DIV: if (div_done) state_next = ST_ERR;
            ST_ERR:     state_next = ST_P_MUL;
            ST_P_MUL:
            begin
                if (mul_done)
                begin
                    state_next = outside_band ? ST_I_MUL : ST_D_MUL;
                end
            end
            ST_I_MUL:   if (mul_done) state_next = ST_I_DT;
            ST_I_DT:    if (mul_done) state_next = ST_D_MUL;
            ST_D_MUL:   if (mul_done) state_next = ST_D_DIV;
            ST_D_DIV:   if (div_done) state_next = ST_PID;
            ST_PID:     state_next = ST_M_MUL;
            ST_M_MUL:   if (mul_done) state_next = ST_M_DIV;
            ST_M_DIV:   if (div_done) state_next = ST_DONE;
            ST_DONE:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // unit commands and operands
    always_comb
    begin
        mul_cmd = '0;
        div_cmd = '0;
        mul_a   = err_wide;
        mul_b   = '0;
        div_dvd = mul_prod;
        div_dsr = span_oc;
        case (state_reg)
            ST_FF_MUL:
            begin
                mul_cmd = '{start: !launch_reg, steps: STEP_W'(FF_MUL_N)};
                mul_a   = s_wide - closed_wide;
                mul_b   = pwm_diff;
            end
            ST_FF_DIV:
            begin
                div_cmd = '{start: !launch_reg, steps: STEP_W'(FF_DIV_N)};
                div_dsr = span_oc;
            end
            ST_POS_MUL:
            begin
                mul_cmd = '{start: !launch_reg, steps: STEP_W'(POS_MUL_N)};
                mul_a   = s_wide - open_wide;
                mul_b   = MUL_BW'(POS_SCALE);
            end
            ST_POS_DIV:
            begin
                div_cmd = '{start: !launch_reg, steps: STEP_W'(POS_DIV_N)};
                div_dsr = span_co;
            end
            ST_P_MUL:
            begin
                mul_cmd = '{start: !launch_reg, steps: STEP_W'(GAIN_N)};
                mul_b   = {8'b0, kp_reg};
            end
            ST_I_MUL:
            begin
                mul_cmd = '{start: !launch_reg, steps: STEP_W'(GAIN_N)};
                mul_b   = {8'b0, ki_reg};
            end
            ST_I_DT:
            begin
                mul_cmd = '{start: !launch_reg, steps: STEP_W'(DT_N)};
                mul_a   = mul_prod;
                mul_b   = {28'b0, dt_reg};
            end
            ST_D_MUL:
            begin
                mul_cmd = '{start: !launch_reg, steps: STEP_W'(GAIN_N)};
                mul_a   = dp_wide;
                mul_b   = {8'b0, kd_reg};
            end
            ST_D_DIV:
            begin
                div_cmd = '{start: !launch_reg, steps: STEP_W'(D_DIV_N)};
                div_dsr = {16'b0, dt_reg};
            end
            ST_M_MUL:
            begin
                mul_cmd = '{start: !launch_reg, steps: STEP_W'(M_MUL_N)};
                mul_a   = pid_off;
                mul_b   = MUL_BW'(DUTY_SPAN);
            end
            ST_M_DIV:
            begin
                div_cmd = '{start: !launch_reg, steps: STEP_W'(M_DIV_N)};
                div_dsr = DIV_DW'(2 * PID_SPAN);
            end
            default:
            begin
                mul_cmd = '0;
                div_cmd = '0;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            launch_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            last_reg       <= '0;
            integ_reg      <= '0;
            closed_reg     <= 13'd843;
            open_reg       <= 13'd4277;
            pwm_open_reg   <= 8'd60;
            pwm_closed_reg <= 8'd80;
            kp_reg         <= 24'd11520;
            kd_reg         <= 24'd512000;
            ki_reg         <= 24'd51;
        end
        else
        begin
            state_reg <= state_next;

            // mark a unit as launched until it reports back
            if (mul_cmd.start || div_cmd.start)
            begin
                launch_reg <= 1'b1;
            end
            else if (op_done)
            begin
                launch_reg <= 1'b0;
            end

            if (state_reg == ST_ERR)
            begin
                last_reg <= pos_reg;
            end
            if (state_reg == ST_I_DT && mul_done)
            begin
                integ_reg <= integ_val;
            end

            if (state_reg == ST_DONE && (!m_valid_reg || m_tready))
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SENSOR_CLOSED: closed_reg     <= cfg_data[12:0];
                    REG_SENSOR_OPEN:   open_reg       <= cfg_data[12:0];
                    REG_PWM_OPEN:      pwm_open_reg   <= cfg_data[7:0];
                    REG_PWM_CLOSED:    pwm_closed_reg <= cfg_data[7:0];
                    REG_GAIN_PROP:     kp_reg         <= cfg_data;
                    REG_GAIN_DERIV:    kd_reg         <= cfg_data;
                    REG_GAIN_INTEG:    ki_reg         <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            s_reg     <= smp_sum[SUM_W-1:3];
            angle_reg <= in_angle;
            dt_reg    <= in_dt;
            if (span_zero)
            begin
                ff_reg  <= {18'b0, pwm_closed_reg};
                pos_reg <= '0;
            end
        end
        if (state_reg == ST_FF_DIV && div_done)
        begin
            ff_reg <= ff_val;
        end
        if (state_reg == ST_POS_DIV && div_done)
        begin
            pos_reg <= pos_val;
        end
        if (state_reg == ST_ERR)
        begin
            err_reg <= err_val;
            dp_reg  <= dp_val;
        end
        if (state_reg == ST_P_MUL && mul_done)
        begin
            p_reg <= mul_prod[49:0];
        end
        if (state_reg == ST_D_DIV && div_done)
        begin
            d_reg <= div_quo[49:0];
        end
        if (state_reg == ST_PID)
        begin
            pid_reg <= pid_rnd[51:8];
        end
        if (state_reg == ST_M_DIV && div_done)
        begin
            duty_reg <= duty_val;
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_tready))
        begin
            m_duty_reg   <= duty_reg;
            m_sensor_reg <= 11'(s_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'b0, m_sensor_reg, m_duty_reg};

endmodule

FILE: design/vpf_checker.sv
// ----------------------------------------------------------------------------
// vpf_checker
// Port-level checks of the valve controller, bound to the top level.
// ----------------------------------------------------------------------------
module vpf_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // hold the result word while the sink stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // one word in flight: drop ready right after an accept
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word accepted while busy");

    // a new result only comes out of a busy cycle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without work");

    // fill bits above the sensor value stay zero
    a_fill_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:19] == 5'd0)
        else $error("nonzero fill in result word");

endmodule

bind valve_pid_with_feedforward_core vpf_checker u_vpf_checker (.*);
